// ===== hw/rtl/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

    // Width of the dead band register
    localparam int EPS_BITS = 20;

    // Result stream width: three flags padded to one byte
    localparam int RES_BITS = 8;

    // Edge mode codes carried on the request side user bits
    localparam logic MODE_CLOSED = 1'b0;
    localparam logic MODE_OPEN   = 1'b1;

    // Pipeline control shared with the split multipliers
    typedef struct packed {
        logic advance;   // whole pipeline moves this cycle
        logic valid_a;   // operands at the multiplier inputs are live
        logic valid_b;   // partial products inside the multiplier are live
    } ptt_mul_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptt_wide_mul.sv =====
`default_nettype none

// Two-stage signed multiplier: operands split into halves, four partial
// products in the first stage, shifted sum in the second.
module ptt_wide_mul
    import ptt_pkg::*;
#(
    parameter int W = 35
)
(
    input  wire                   clk,
    input  wire ptt_mul_ctl_t     ctl,
    input  wire logic signed [W-1:0]   a,
    input  wire logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;
    localparam int LL = 2 * LO + 2;
    localparam int LH = LO + 1 + HI;
    localparam int HH = 2 * HI;
    localparam int PW = 2 * W;

    logic signed [LO:0]    a_lo;
    logic signed [LO:0]    b_lo;
    logic signed [HI-1:0]  a_hi;
    logic signed [HI-1:0]  b_hi;

    logic signed [LL-1:0]  ll_next, ll_reg;
    logic signed [LH-1:0]  lh_next, lh_reg;
    logic signed [LH-1:0]  hl_next, hl_reg;
    logic signed [HH-1:0]  hh_next, hh_reg;
    logic signed [PW-1:0]  p_next, p_reg;

    // Split operands: low halves unsigned, high halves keep the sign
    assign a_lo = {1'b0, a[LO-1:0]};
    assign b_lo = {1'b0, b[LO-1:0]};
    assign a_hi = a[W-1:LO];
    assign b_hi = b[W-1:LO];

    // Form partial products
    always_comb
    begin
        ll_next = a_lo * b_lo;
        lh_next = a_lo * b_hi;
        hl_next = a_hi * b_lo;
        hh_next = a_hi * b_hi;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid_a)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
    end

    // Recombine partial products at their weights
    always_comb
    begin
        p_next = (PW'(hh_reg) <<< (2 * LO))
               + ((PW'(lh_reg) + PW'(hl_reg)) <<< LO)
               + PW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid_b)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_triangle_test.sv =====
`default_nettype none

// Channel   Dir  Handshake              Contents
// s_*       in   s_tvalid / s_tready    tdata: ax ay bx by cx cy point_x point_y; tuser: mode
// m_*       out  m_tvalid / m_tready    tdata: inside_res in_circumcircle degenerate
// cfg_*     in   cfg_wr_en              cfg_wr_data: epsilon
//
// One request per cycle unless a stall on m_tready holds the pipeline.
// The depth is set by the circumcircle term: coordinate differences, products,
// sums, split partial products, recombination, final three-way sum.
// Reset clears all valid bits and epsilon. A stall on m_tready freezes every
// stage together; s_tready drops only while the result register is held full.
module point_in_triangle_test
    import ptt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // ax, ay, bx, by, cx, cy, point_x, point_y (COORD_BITS each, from bit 0)
    input  wire [8*COORD_BITS-1:0]      s_tdata,
    // mode
    input  wire [0:0]                   s_tuser,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // inside_res, in_circumcircle, degenerate, then zero padding
    output logic [RES_BITS-1:0]         m_tdata,
    input  wire                         cfg_wr_en,
    input  wire [EPS_BITS-1:0]          cfg_wr_data
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;            // coordinate difference
    localparam int PW2 = 2 * DW;            // product of two differences
    localparam int W   = PW2 + 1;           // determinant, squared length
    localparam int XW  = 2 * W + 2;         // circumcircle sum
    localparam int CW  = (W + 1 > EPS_BITS) ? W + 1 : EPS_BITS;

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        mag_w = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic          adv;
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic [EPS_BITS-1:0] eps_reg;
    ptt_mul_ctl_t  mul_ctl;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;

    assign mul_ctl.advance = adv;
    assign mul_ctl.valid_a = v3_reg;
    assign mul_ctl.valid_b = v4_reg;

    // Advance valid bits and hold epsilon
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            eps_reg       <= '0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg        <= s_tvalid;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
            end
            if (cfg_wr_en)
            begin
                eps_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: differences
    // ---------------------------------------------------------------
    logic signed [CB-1:0] ax, ay, bx, by, cx, cy, px, py;

    assign ax = s_tdata[0*CB +: CB];
    assign ay = s_tdata[1*CB +: CB];
    assign bx = s_tdata[2*CB +: CB];
    assign by = s_tdata[3*CB +: CB];
    assign cx = s_tdata[4*CB +: CB];
    assign cy = s_tdata[5*CB +: CB];
    assign px = s_tdata[6*CB +: CB];
    assign py = s_tdata[7*CB +: CB];

    logic signed [DW-1:0] t_ax_reg, t_ay_reg, t_bx_reg, t_by_reg, t_px_reg, t_py_reg;
    logic signed [DW-1:0] q_ax_reg, q_ay_reg, q_bx_reg, q_by_reg, q_cx_reg, q_cy_reg;
    logic                 mode1_reg;

    // Move vertex c to the origin for the circle test, the point for edges
    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
        begin
            t_ax_reg  <= DW'(ax) - DW'(cx);
            t_ay_reg  <= DW'(ay) - DW'(cy);
            t_bx_reg  <= DW'(bx) - DW'(cx);
            t_by_reg  <= DW'(by) - DW'(cy);
            t_px_reg  <= DW'(px) - DW'(cx);
            t_py_reg  <= DW'(py) - DW'(cy);
            q_ax_reg  <= DW'(ax) - DW'(px);
            q_ay_reg  <= DW'(ay) - DW'(py);
            q_bx_reg  <= DW'(bx) - DW'(px);
            q_by_reg  <= DW'(by) - DW'(py);
            q_cx_reg  <= DW'(cx) - DW'(px);
            q_cy_reg  <= DW'(cy) - DW'(py);
            mode1_reg <= s_tuser[0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: products of differences
    // ---------------------------------------------------------------
    logic signed [PW2-1:0] m_d0_reg, m_d1_reg;
    logic signed [PW2-1:0] sq_ax_reg, sq_ay_reg, sq_bx_reg, sq_by_reg, sq_px_reg, sq_py_reg;
    logic signed [PW2-1:0] m_c0_reg, m_c1_reg, m_a0_reg, m_a1_reg;
    logic signed [PW2-1:0] o0a_reg, o0b_reg, o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    logic                  mode2_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v1_reg)
        begin
            m_d0_reg  <= t_ax_reg * t_by_reg;
            m_d1_reg  <= t_bx_reg * t_ay_reg;
            sq_ax_reg <= t_ax_reg * t_ax_reg;
            sq_ay_reg <= t_ay_reg * t_ay_reg;
            sq_bx_reg <= t_bx_reg * t_bx_reg;
            sq_by_reg <= t_by_reg * t_by_reg;
            sq_px_reg <= t_px_reg * t_px_reg;
            sq_py_reg <= t_py_reg * t_py_reg;
            m_c0_reg  <= t_by_reg * t_px_reg;
            m_c1_reg  <= t_bx_reg * t_py_reg;
            m_a0_reg  <= t_ax_reg * t_py_reg;
            m_a1_reg  <= t_ay_reg * t_px_reg;
            o0a_reg   <= q_bx_reg * q_cy_reg;
            o0b_reg   <= q_by_reg * q_cx_reg;
            o1a_reg   <= q_cx_reg * q_ay_reg;
            o1b_reg   <= q_cy_reg * q_ax_reg;
            o2a_reg   <= q_ax_reg * q_by_reg;
            o2b_reg   <= q_ay_reg * q_bx_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: determinants and squared lengths
    // ---------------------------------------------------------------
    logic signed [W-1:0] d_reg, aa_reg, bb_reg, pp_reg, cbp_reg, cap_reg;
    logic signed [W-1:0] det0_reg, det1_reg, det2_reg;
    logic                mode3_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg)
        begin
            d_reg     <= W'(m_d0_reg) - W'(m_d1_reg);
            aa_reg    <= W'(sq_ax_reg) + W'(sq_ay_reg);
            bb_reg    <= W'(sq_bx_reg) + W'(sq_by_reg);
            pp_reg    <= W'(sq_px_reg) + W'(sq_py_reg);
            cbp_reg   <= W'(m_c0_reg) - W'(m_c1_reg);
            cap_reg   <= W'(m_a0_reg) - W'(m_a1_reg);
            det0_reg  <= W'(o0a_reg) - W'(o0b_reg);
            det1_reg  <= W'(o1a_reg) - W'(o1b_reg);
            det2_reg  <= W'(o2a_reg) - W'(o2b_reg);
            mode3_reg <= mode2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stages 4-5: circumcircle products in split multipliers
    // ---------------------------------------------------------------
    logic signed [2*W-1:0] prod_dp, prod_ac, prod_bc;

    ptt_wide_mul #(.W(W)) u_mul_dp
    (
        .clk (clk),
        .ctl (mul_ctl),
        .a   (d_reg),
        .b   (pp_reg),
        .p   (prod_dp)
    );

    ptt_wide_mul #(.W(W)) u_mul_ac
    (
        .clk (clk),
        .ctl (mul_ctl),
        .a   (aa_reg),
        .b   (cbp_reg),
        .p   (prod_ac)
    );

    ptt_wide_mul #(.W(W)) u_mul_bc
    (
        .clk (clk),
        .ctl (mul_ctl),
        .a   (bb_reg),
        .b   (cap_reg),
        .p   (prod_bc)
    );

    // Stage 4 flags: degenerate test and edge orientations
    logic [W-1:0]  d_mag, det0_mag, det1_mag, det2_mag;
    logic [2:0]    band;
    logic [2:0]    sgn;

    always_comb
    begin
        d_mag    = mag_w(d_reg);
        det0_mag = mag_w(det0_reg);
        det1_mag = mag_w(det1_reg);
        det2_mag = mag_w(det2_reg);
        band[0]  = CW'(det0_mag) <= CW'(eps_reg);
        band[1]  = CW'(det1_mag) <= CW'(eps_reg);
        band[2]  = CW'(det2_mag) <= CW'(eps_reg);
        sgn      = {det2_reg[W-1], det1_reg[W-1], det0_reg[W-1]};
    end

    logic       degen4_reg, dzero4_reg, dneg4_reg, mode4_reg;
    logic [2:0] opos4_reg, oneg4_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v3_reg)
        begin
            degen4_reg <= CW'({d_mag, 1'b0}) < CW'(eps_reg);
            dzero4_reg <= (d_reg == '0);
            dneg4_reg  <= d_reg[W-1];
            opos4_reg  <= ~band & ~sgn;
            oneg4_reg  <= ~band & sgn;
            mode4_reg  <= mode3_reg;
        end
    end

    // Stage 5: carry flags alongside the recombined products
    logic       degen5_reg, dzero5_reg, dneg5_reg, edges5_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v4_reg)
        begin
            degen5_reg <= degen4_reg;
            dzero5_reg <= dzero4_reg;
            dneg5_reg  <= dneg4_reg;
            if (mode4_reg == MODE_OPEN)
            begin
                edges5_reg <= &opos4_reg;
            end
            else
            begin
                edges5_reg <= ~|oneg4_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: circumcircle sign and result register
    // ---------------------------------------------------------------
    logic signed [XW-1:0] x_sum;
    logic                 incirc;

    always_comb
    begin
        x_sum  = XW'(prod_dp) - XW'(prod_ac) - XW'(prod_bc);
        incirc = degen5_reg || dzero5_reg || (x_sum == '0)
              || (x_sum[XW-1] != dneg5_reg);
    end

    logic inside_reg, incirc_reg, degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv && v5_reg)
        begin
            inside_reg <= incirc && edges5_reg;
            incirc_reg <= incirc;
            degen_reg  <= degen5_reg;
        end
    end

    assign m_tdata = {{(RES_BITS - 3){1'b0}}, degen_reg, incirc_reg, inside_reg};

endmodule

`default_nettype wire

// ===== verif/ptt_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and epsilon channels of the point-in-triangle
// block, predicts each verdict and compares it with the result stream.
module ptt_checker
    import ptt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    input  wire                         s_tready,
    // ax, ay, bx, by, cx, cy, point_x, point_y (COORD_BITS each, from bit 0)
    input  wire [8*COORD_BITS-1:0]      s_tdata,
    // mode
    input  wire [0:0]                   s_tuser,
    input  wire                         m_tvalid,
    input  wire                         m_tready,
    // inside_res, in_circumcircle, degenerate, then zero padding
    input  wire [RES_BITS-1:0]          m_tdata,
    input  wire                         cfg_wr_en,
    input  wire [EPS_BITS-1:0]          cfg_wr_data,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic inside_res;
        logic in_circumcircle;
        logic degenerate;
    } verdict_t;

    verdict_t               verdicts_due[$];
    logic [EPS_BITS-1:0]    eps_shadow;
    int                     mismatches;

    // Sign of the orientation determinant of (u, v) seen from p, zero in the dead band
    function automatic int edge_orientation(longint ux, longint uy, longint vx, longint vy,
                                            longint px, longint py, longint eps);
        longint det;
        longint mag;
        det = (ux - px) * (vy - py) - (uy - py) * (vx - px);
        mag = (det < 0) ? -det : det;
        if (mag <= eps)
            return 0;
        return (det > 0) ? 1 : -1;
    endfunction

    // Work out the three flags for one request
    function automatic verdict_t classify_query(logic [8*COORD_BITS-1:0] coords,
                                                logic mode, logic [EPS_BITS-1:0] eps_val);
        longint             v[8];
        longint             eps;
        longint             tax, tay, tbx, tby, tpx, tpy;
        longint             d, dmag2;
        logic signed [127:0] w_d, w_aa, w_bb, w_pp, w_cbp, w_cap, acc;
        int                 o0, o1, o2;
        logic               edges_ok;
        verdict_t           r;

        for (int i = 0; i < 8; i++)
            v[i] = longint'($signed(coords[i*COORD_BITS +: COORD_BITS]));
        eps = longint'(eps_val);

        // Move vertex c to the origin
        tax = v[0] - v[4];
        tay = v[1] - v[5];
        tbx = v[2] - v[4];
        tby = v[3] - v[5];
        tpx = v[6] - v[4];
        tpy = v[7] - v[5];
        d = tax * tby - tbx * tay;
        dmag2 = ((d < 0) ? -d : d) * 2;
        r.degenerate = (dmag2 < eps);

        // Circumcircle prefilter, exact in 128 bits
        if (r.degenerate || d == 0)
        begin
            r.in_circumcircle = 1'b1;
        end
        else
        begin
            w_d   = d;
            w_aa  = tax * tax + tay * tay;
            w_bb  = tbx * tbx + tby * tby;
            w_pp  = tpx * tpx + tpy * tpy;
            w_cbp = tby * tpx - tbx * tpy;
            w_cap = tax * tpy - tay * tpx;
            acc = w_d * w_pp - w_aa * w_cbp - w_bb * w_cap;
            r.in_circumcircle = (acc == 0) || ((acc < 0) != (d < 0));
        end

        // Edges b-c, c-a, a-b
        o0 = edge_orientation(v[2], v[3], v[4], v[5], v[6], v[7], eps);
        o1 = edge_orientation(v[4], v[5], v[0], v[1], v[6], v[7], eps);
        o2 = edge_orientation(v[0], v[1], v[2], v[3], v[6], v[7], eps);
        if (mode == MODE_OPEN)
            edges_ok = (o0 > 0) && (o1 > 0) && (o2 > 0);
        else
            edges_ok = (o0 != -1) && (o1 != -1) && (o2 != -1);

        r.inside_res = r.in_circumcircle && edges_ok;
        return r;
    endfunction

    // Track epsilon, queue a verdict per request, compare each result
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            eps_shadow = '0;
            verdicts_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                eps_shadow = cfg_wr_data;
            if (s_tvalid && s_tready)
                verdicts_due.push_back(classify_query(s_tdata, s_tuser[0], eps_shadow));
            if (m_tvalid && m_tready)
            begin
                got.inside_res      = m_tdata[0];
                got.in_circumcircle = m_tdata[1];
                got.degenerate      = m_tdata[2];
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result with no request outstanding: ",
                                  "inside=%b circ=%b degen=%b"},
                                 $realtime, got.inside_res, got.in_circumcircle,
                                 got.degenerate);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got.inside_res != want.inside_res
                        || got.in_circumcircle != want.in_circumcircle
                        || got.degenerate != want.degenerate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch expected inside=%b circ=%b degen=%b, ",
                                      "got inside=%b circ=%b degen=%b"},
                                     $realtime, want.inside_res, want.in_circumcircle,
                                     want.degenerate, got.inside_res, got.in_circumcircle,
                                     got.degenerate);
                    end
                end
            end
            fail_count <= mismatches;
            pending <= verdicts_due.size();
        end
    end

endmodule

// ===== verif/tb_point_in_triangle_test.sv =====
`timescale 1ns / 1ps

module tb_point_in_triangle_test;
    import ptt_pkg::*;

    localparam int CB          = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 290;

    typedef struct packed {
        logic               mode;
        logic [8*CB-1:0]    coords;
    } request_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [8*CB-1:0]        s_tdata;    // ax, ay, bx, by, cx, cy, point_x, point_y
    logic [0:0]             s_tuser;    // mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RES_BITS-1:0]    m_tdata;    // inside_res, in_circumcircle, degenerate
    logic                   cfg_wr_en;
    logic [EPS_BITS-1:0]    cfg_wr_data;
    int                     fail_count;
    int                     pending;
    bit                     idle_on = 1'b1;

    point_in_triangle_test #(.COORD_BITS(CB)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ptt_checker #(.COORD_BITS(CB)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic request_t make_request(int ax, int ay, int bx, int by, int cx, int cy,
                                              int px, int py, logic mode);
        int       v[8];
        request_t r;
        v[0] = ax; v[1] = ay; v[2] = bx; v[3] = by;
        v[4] = cx; v[5] = cy; v[6] = px; v[7] = py;
        for (int i = 0; i < 8; i++)
            r.coords[i*CB +: CB] = v[i][CB-1:0];
        r.mode = mode;
        return r;
    endfunction

    // Mix of wide random, tight clusters, bounded radii, points on vertices or edges and collinear vertices
    function automatic request_t random_request();
        int   v[8];
        int   pick, ox, oy, rad, j, k, dx, dy;
        logic mode;
        pick = span(0, 99);
        mode = $urandom_range(0, 1) ? MODE_OPEN : MODE_CLOSED;
        if (pick < 20)
        begin
            for (int i = 0; i < 8; i++)
                v[i] = span(-32768, 32767);
        end
        else if (pick < 50)
        begin
            ox = span(-32000, 32000);
            oy = span(-32000, 32000);
            for (int i = 0; i < 4; i++)
            begin
                v[2*i]   = ox + span(-6, 6);
                v[2*i+1] = oy + span(-6, 6);
            end
        end
        else if (pick < 75)
        begin
            case (span(0, 3))
                0: rad = 64;
                1: rad = 1024;
                2: rad = 4096;
                default: rad = 32767;
            endcase
            for (int i = 0; i < 8; i++)
                v[i] = span(-rad, rad);
        end
        else if (pick < 90)
        begin
            // Place the point on a vertex or near the middle of an edge
            for (int i = 0; i < 6; i++)
                v[i] = span(-1024, 1024);
            j = span(0, 2);
            k = (j + 1) % 3;
            if (span(0, 2) == 0)
            begin
                v[6] = v[2*j];
                v[7] = v[2*j+1];
            end
            else
            begin
                v[6] = (v[2*j] + v[2*k]) / 2;
                v[7] = (v[2*j+1] + v[2*k+1]) / 2;
            end
        end
        else
        begin
            // Collinear vertices, point on or beside the line
            ox = span(-30000, 30000);
            oy = span(-30000, 30000);
            dx = span(-40, 40);
            dy = span(-40, 40);
            for (int i = 0; i < 4; i++)
            begin
                k = span(-20, 20);
                v[2*i]   = ox + dx * k;
                v[2*i+1] = oy + dy * k;
            end
            v[6] = v[6] + span(-1, 1);
        end
        return make_request(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], mode);
    endfunction

    // Offer one request, with an optional gap, and hold it until accepted
    task automatic send_request(input request_t rq);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rq.coords;
        s_tuser  <= rq.mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every verdict has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_epsilon(input logic [EPS_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side backpressure in random bursts
    initial
    begin : result_sink
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0 && idle_on)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [EPS_BITS-1:0] eps_val;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= MODE_CLOSED;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset dead band of zero
        send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, MODE_CLOSED));
        send_request(make_request(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, MODE_OPEN));
        send_request(make_request(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, MODE_CLOSED));
        send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                  0, 0, MODE_CLOSED));
        send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                  0, 0, MODE_OPEN));
        send_request(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                  32767, 32767, MODE_CLOSED));
        send_request(make_request(0, 0, 10, 0, 0, 10, 2, 2, MODE_OPEN));
        send_request(make_request(0, 0, 10, 0, 0, 10, 5, 0, MODE_CLOSED));
        send_request(make_request(0, 0, 10, 0, 0, 10, 5, 0, MODE_OPEN));
        send_request(make_request(0, 0, 10, 0, 0, 10, 0, 0, MODE_CLOSED));
        send_request(make_request(0, 0, 10, 0, 0, 10, 0, 0, MODE_OPEN));
        send_request(make_request(0, 0, 0, 10, 10, 0, 2, 2, MODE_CLOSED));
        send_request(make_request(0, 0, 0, 10, 10, 0, 2, 2, MODE_OPEN));
        send_request(make_request(0, 0, 5, 5, 10, 10, 3, 3, MODE_CLOSED));
        send_request(make_request(0, 0, 5, 5, 10, 10, 3, 4, MODE_CLOSED));
        send_request(make_request(1, 0, 0, 1, -1, 0, 0, -1, MODE_CLOSED));
        send_request(make_request(1, 0, 0, 1, -1, 0, 0, 0, MODE_CLOSED));
        send_request(make_request(0, 0, 100, 0, 50, 1, 50, -200, MODE_CLOSED));
        send_request(make_request(32767, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, MODE_OPEN));
        send_request(make_request(32767, -32768, -32768, 32767, 32767, 32767,
                                  32767, -32768, MODE_OPEN));
        send_request(make_request(-32768, 32767, 32767, -32768, -32768, -32768,
                                  -100, -100, MODE_CLOSED));

        // Random phases, each under its own dead band
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: eps_val = '1;
                1: eps_val = 20'd1;
                2: eps_val = EPS_BITS'(span(2, 4095));
                3: eps_val = EPS_BITS'(span(4096, 1048574));
                4: eps_val = '0;
                default: eps_val = EPS_BITS'($urandom_range(0, 1048575));
            endcase
            drain();
            if (ph == 5)
                idle_on = 1'b0;
            write_epsilon(eps_val);
            repeat (PHASE_ITEMS)
                send_request(random_request());
        end

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
